@@ src/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

   localparam int FIELD_W = 32;
   localparam int SCALE   = 100;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Control that travels with the two numerators into the divider.
   typedef struct packed {
      logic valid;
      logic neg_re;
      logic neg_im;
      logic zero;
   } div_ctl_type;

   // Status returned by the divider along with the rounded quotients.
   typedef struct packed {
      logic valid;
      logic neg_re;
      logic neg_im;
      logic zero;
      logic big_re;
      logic big_im;
   } div_flags_type;

endpackage

@@ src/cau_ifs.sv @@
// Request and response channel interfaces of the complex arithmetic unit.
interface cau_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic signed [cau_pkg::FIELD_W-1:0]  a_re;
   logic signed [cau_pkg::FIELD_W-1:0]  a_im;
   logic signed [cau_pkg::FIELD_W-1:0]  b_re;
   logic signed [cau_pkg::FIELD_W-1:0]  b_im;

   modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cau_pkg::FIELD_W-1:0]  res_re;
   logic signed [cau_pkg::FIELD_W-1:0]  res_im;
   logic                                div_zero;
   logic                                saturated;

   modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
   modport sink   (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

@@ src/cau_div_pipe.sv @@
// Pipelined restoring divider: two numerators over a shared divisor, one quotient bit a stage.
module cau_div_pipe #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  cau_pkg::div_ctl_type          in_ctl,
   input  logic [2*VALUE_WIDTH+6:0]      in_num_re,
   input  logic [2*VALUE_WIDTH+6:0]      in_num_im,
   input  logic [2*VALUE_WIDTH-1:0]      in_den,
   output cau_pkg::div_flags_type        out_flags,
   output logic [VALUE_WIDTH+1:0]        out_quo_re,
   output logic [VALUE_WIDTH+1:0]        out_quo_im
);
   import cau_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int DW = 2 * W;
   localparam int NW = 2 * W + 7;
   localparam int CW = 3 * W + 2;
   localparam int QW = W + 1;
   localparam int NS = W + 1;

   div_ctl_type      ctl_ff    [0:NS];
   logic [NW-1:0]    rem_re_ff [0:NS];
   logic [NW-1:0]    rem_im_ff [0:NS];
   logic [DW-1:0]    den_ff    [0:NS];
   logic [QW-1:0]    quo_re_ff [0:NS];
   logic [QW-1:0]    quo_im_ff [0:NS];
   logic             big_re_ff [0:NS];
   logic             big_im_ff [0:NS];

   logic             big_re_in;
   logic             big_im_in;
   logic [CW-1:0]    den_top;
   logic             rnd_re;
   logic             rnd_im;

   // Flag quotients that would need more than QW bits
   always_comb begin
      den_top   = CW'(in_den) << QW;
      big_re_in = CW'(in_num_re) >= den_top;
      big_im_in = CW'(in_num_im) >= den_top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else if (enable) begin
         ctl_ff[0]    <= in_ctl;
         rem_re_ff[0] <= in_num_re;
         rem_im_ff[0] <= in_num_im;
         den_ff[0]    <= in_den;
         quo_re_ff[0] <= '0;
         quo_im_ff[0] <= '0;
         big_re_ff[0] <= big_re_in;
         big_im_ff[0] <= big_im_in;
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar s = 1; s <= NS; s++) begin : g_stage
      localparam int BIT = NS - s;
      logic [CW-1:0] den_sh;
      logic          ge_re;
      logic          ge_im;
      logic [NW-1:0] rem_re_in;
      logic [NW-1:0] rem_im_in;
      logic [QW-1:0] quo_re_in;
      logic [QW-1:0] quo_im_in;

      always_comb begin
         den_sh    = CW'(den_ff[s-1]) << BIT;
         ge_re     = CW'(rem_re_ff[s-1]) >= den_sh;
         ge_im     = CW'(rem_im_ff[s-1]) >= den_sh;
         rem_re_in = ge_re ? NW'(CW'(rem_re_ff[s-1]) - den_sh) : rem_re_ff[s-1];
         rem_im_in = ge_im ? NW'(CW'(rem_im_ff[s-1]) - den_sh) : rem_im_ff[s-1];
         quo_re_in = quo_re_ff[s-1] | (QW'(ge_re) << BIT);
         quo_im_in = quo_im_ff[s-1] | (QW'(ge_im) << BIT);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else if (enable) begin
            ctl_ff[s]    <= ctl_ff[s-1];
            rem_re_ff[s] <= rem_re_in;
            rem_im_ff[s] <= rem_im_in;
            den_ff[s]    <= den_ff[s-1];
            quo_re_ff[s] <= quo_re_in;
            quo_im_ff[s] <= quo_im_in;
            big_re_ff[s] <= big_re_ff[s-1];
            big_im_ff[s] <= big_im_ff[s-1];
         end
      end
   end

   // Round half away from zero: bump when twice the remainder reaches the divisor
   always_comb begin
      rnd_re = {rem_re_ff[NS][DW-1:0], 1'b0} >= {1'b0, den_ff[NS]};
      rnd_im = {rem_im_ff[NS][DW-1:0], 1'b0} >= {1'b0, den_ff[NS]};
      out_quo_re = {1'b0, quo_re_ff[NS]} + (W+2)'(rnd_re);
      out_quo_im = {1'b0, quo_im_ff[NS]} + (W+2)'(rnd_im);
      out_flags.valid  = ctl_ff[NS].valid;
      out_flags.neg_re = ctl_ff[NS].neg_re;
      out_flags.neg_im = ctl_ff[NS].neg_im;
      out_flags.zero   = ctl_ff[NS].zero;
      out_flags.big_re = big_re_ff[NS];
      out_flags.big_im = big_im_ff[NS];
   end

endmodule

@@ src/complex_arithmetic_unit.sv @@
// Top level of the complex arithmetic unit.
// Takes one transaction per cycle while the response is not stalled and returns the results
// in the order accepted. Every operation runs through the same pipeline: operand capture,
// products, sums, magnitude, scaling, a range check, VALUE_WIDTH + 1 restoring divider stages
// (one quotient bit each, which set the depth) and a rounding/saturation output register.
// Add and subtract divide by one, multiply by one hundred, and divide by |b|^2 after scaling
// the numerator by one hundred. A stalled response holds the whole pipeline.
module complex_arithmetic_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_bus,
   cau_rsp_if.source  rsp_bus
);
   import cau_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int DW = 2 * W;
   localparam int NW = 2 * W + 7;
   localparam logic [W+1:0] NEG_LIM = (W+2)'(64'd1 << (W - 1));
   localparam logic [W+1:0] POS_LIM = NEG_LIM - (W+2)'(1);

   logic enable;

   // stage 1: operands
   logic          s1_vld_ff;
   op_type        s1_op_ff;
   logic [W-1:0]  ar_ff, ai_ff, br_ff, bi_ff;

   // stage 2: products and part sums
   logic          s2_vld_ff;
   op_type        s2_op_ff;
   logic          s2_zero_ff;
   logic [DW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, q_rr_ff, q_ii_ff;
   logic [W:0]    sum_re_ff, sum_im_ff;
   logic [DW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, q_rr_in, q_ii_in;
   logic [W:0]    sum_re_in, sum_im_in;

   // stage 3: signed numerators and divisor
   logic          s3_vld_ff;
   op_type        s3_op_ff;
   logic          s3_zero_ff;
   logic [DW:0]   num_re_ff, num_im_ff;
   logic [DW-1:0] s3_den_ff;
   logic [DW:0]   num_re_in, num_im_in;
   logic [DW-1:0] den_in;

   // stage 4: sign and magnitude
   logic          s4_vld_ff;
   op_type        s4_op_ff;
   logic          s4_zero_ff;
   logic          neg_re_ff, neg_im_ff;
   logic [DW-1:0] mag_re_ff, mag_im_ff;
   logic [DW-1:0] s4_den_ff;
   logic [DW:0]   abs_re, abs_im;

   // stage 5: scaled numerators into the divider
   logic          s5_vld_ff;
   logic          s5_neg_re_ff, s5_neg_im_ff, s5_zero_ff;
   div_ctl_type   s5_ctl;
   logic [NW-1:0] s5_num_re_ff, s5_num_im_ff;
   logic [DW-1:0] s5_den_ff;

   div_flags_type dv_flags;
   logic [W+1:0]  dv_quo_re, dv_quo_im;

   // response register
   logic                 rsp_vld_ff;
   logic [FIELD_W-1:0]   res_re_ff, res_im_ff;
   logic                 dz_ff, sat_ff;
   logic [W:0]           sat_re, sat_im;
   logic [FIELD_W-1:0]   res_re_in, res_im_in;
   logic                 sat_in;

   // Clip a rounded magnitude to the signed range; returns {clipped, value}
   function automatic logic [W:0] saturate(input logic neg, input logic big,
                                           input logic [W+1:0] mag);
      logic         clip;
      logic [W+1:0] val;
      if (neg) begin
         clip = big || (mag > NEG_LIM);
         val  = clip ? NEG_LIM : mag;
         val  = ~val + (W+2)'(1);
      end else begin
         clip = big || (mag > POS_LIM);
         val  = clip ? POS_LIM : mag;
      end
      return {clip, val[W-1:0]};
   endfunction

   // Advance everything unless a finished result is still waiting
   assign enable        = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = enable;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (enable) begin
         s1_vld_ff <= req_bus.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         rsp_vld_ff <= dv_flags.valid;
      end
   end

   // Products and add/subtract parts
   always_comb begin
      p_rr_in = $signed(ar_ff) * $signed(br_ff);
      p_ii_in = $signed(ai_ff) * $signed(bi_ff);
      p_ri_in = $signed(ar_ff) * $signed(bi_ff);
      p_ir_in = $signed(ai_ff) * $signed(br_ff);
      q_rr_in = $signed(br_ff) * $signed(br_ff);
      q_ii_in = $signed(bi_ff) * $signed(bi_ff);
      if (s1_op_ff == OP_SUB) begin
         sum_re_in = {ar_ff[W-1], ar_ff} - {br_ff[W-1], br_ff};
         sum_im_in = {ai_ff[W-1], ai_ff} - {bi_ff[W-1], bi_ff};
      end else begin
         sum_re_in = {ar_ff[W-1], ar_ff} + {br_ff[W-1], br_ff};
         sum_im_in = {ai_ff[W-1], ai_ff} + {bi_ff[W-1], bi_ff};
      end
   end

   // Pick numerators and divisor per operation
   always_comb begin
      unique case (s2_op_ff)
         OP_ADD, OP_SUB: begin
            num_re_in = {{(DW-W){sum_re_ff[W]}}, sum_re_ff};
            num_im_in = {{(DW-W){sum_im_ff[W]}}, sum_im_ff};
            den_in    = DW'(1);
         end
         OP_MUL: begin
            num_re_in = {p_rr_ff[DW-1], p_rr_ff} - {p_ii_ff[DW-1], p_ii_ff};
            num_im_in = {p_ri_ff[DW-1], p_ri_ff} + {p_ir_ff[DW-1], p_ir_ff};
            den_in    = DW'(SCALE);
         end
         OP_DIV: begin
            num_re_in = {p_rr_ff[DW-1], p_rr_ff} + {p_ii_ff[DW-1], p_ii_ff};
            num_im_in = {p_ir_ff[DW-1], p_ir_ff} - {p_ri_ff[DW-1], p_ri_ff};
            den_in    = q_rr_ff + q_ii_ff;
         end
         default: begin
            num_re_in = '0;
            num_im_in = '0;
            den_in    = DW'(1);
         end
      endcase
   end

   // Magnitudes
   always_comb begin
      abs_re = num_re_ff[DW] ? (DW+1)'(0) - num_re_ff : num_re_ff;
      abs_im = num_im_ff[DW] ? (DW+1)'(0) - num_im_ff : num_im_ff;
   end

   // Payload registers of the front stages
   always_ff @(posedge clock) begin
      if (enable) begin
         s1_op_ff <= op_type'(req_bus.req_type);
         ar_ff    <= req_bus.a_re[W-1:0];
         ai_ff    <= req_bus.a_im[W-1:0];
         br_ff    <= req_bus.b_re[W-1:0];
         bi_ff    <= req_bus.b_im[W-1:0];

         s2_op_ff   <= s1_op_ff;
         s2_zero_ff <= (s1_op_ff == OP_DIV) && (br_ff == '0) && (bi_ff == '0);
         p_rr_ff    <= p_rr_in;
         p_ii_ff    <= p_ii_in;
         p_ri_ff    <= p_ri_in;
         p_ir_ff    <= p_ir_in;
         q_rr_ff    <= q_rr_in;
         q_ii_ff    <= q_ii_in;
         sum_re_ff  <= sum_re_in;
         sum_im_ff  <= sum_im_in;

         s3_op_ff   <= s2_op_ff;
         s3_zero_ff <= s2_zero_ff;
         num_re_ff  <= num_re_in;
         num_im_ff  <= num_im_in;
         s3_den_ff  <= den_in;

         s4_op_ff   <= s3_op_ff;
         s4_zero_ff <= s3_zero_ff;
         neg_re_ff  <= num_re_ff[DW];
         neg_im_ff  <= num_im_ff[DW];
         mag_re_ff  <= abs_re[DW-1:0];
         mag_im_ff  <= abs_im[DW-1:0];
         s4_den_ff  <= s3_den_ff;

         // scale by one hundred for a true divide
         s5_neg_re_ff <= neg_re_ff;
         s5_neg_im_ff <= neg_im_ff;
         s5_zero_ff   <= s4_zero_ff;
         s5_num_re_ff <= (s4_op_ff == OP_DIV) ? NW'(mag_re_ff) * NW'(SCALE) : NW'(mag_re_ff);
         s5_num_im_ff <= (s4_op_ff == OP_DIV) ? NW'(mag_im_ff) * NW'(SCALE) : NW'(mag_im_ff);
         s5_den_ff    <= s4_den_ff;
      end
   end

   // Bundle the control that rides along with the divider
   always_comb begin
      s5_ctl.valid  = s5_vld_ff;
      s5_ctl.neg_re = s5_neg_re_ff;
      s5_ctl.neg_im = s5_neg_im_ff;
      s5_ctl.zero   = s5_zero_ff;
   end

   cau_div_pipe #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_ctl     (s5_ctl),
      .in_num_re  (s5_num_re_ff),
      .in_num_im  (s5_num_im_ff),
      .in_den     (s5_den_ff),
      .out_flags  (dv_flags),
      .out_quo_re (dv_quo_re),
      .out_quo_im (dv_quo_im)
   );

   // Saturate, or force zero on a zero divisor
   always_comb begin
      sat_re = saturate(dv_flags.neg_re, dv_flags.big_re, dv_quo_re);
      sat_im = saturate(dv_flags.neg_im, dv_flags.big_im, dv_quo_im);
      if (dv_flags.zero) begin
         res_re_in = '0;
         res_im_in = '0;
         sat_in    = 1'b0;
      end else begin
         res_re_in = FIELD_W'(sat_re[W-1:0]);
         res_im_in = FIELD_W'(sat_im[W-1:0]);
         sat_in    = sat_re[W] || sat_im[W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= dv_flags.zero;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.res_re    = res_re_ff;
   assign rsp_bus.res_im    = res_im_ff;
   assign rsp_bus.div_zero  = dz_ff;
   assign rsp_bus.saturated = sat_ff;

endmodule
